@@ src/gamma_correct_quad_pixel_blend_macros.svh @@
// Assertion helpers for the gamma-correct quad blend.
`ifndef GAMMA_CORRECT_QUAD_PIXEL_BLEND_MACROS_SVH
`define GAMMA_CORRECT_QUAD_PIXEL_BLEND_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define GCQPB_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gcqpb same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define GCQPB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gcqpb next-cycle check failed");

`endif

@@ src/gcqpb_pkg.sv @@
package gcqpb_pkg;

   // Fixed-point precision of decoded linear light
   localparam int GAMMA_FRAC_BITS = 24;

   localparam int PIXEL_W   = 32;
   localparam int CODE_W    = 8;
   localparam int CODE_COUNT = 1 << CODE_W;
   localparam int PIX_COUNT = 4;
   localparam int CH_COUNT  = PIXEL_W / CODE_W;
   localparam int ALPHA_CH  = CH_COUNT - 1;

   // Decoded value 0..2^F, pair sum, quad sum 0..2^(F+2)
   localparam int DEC_W  = GAMMA_FRAC_BITS + 1;
   localparam int PAIR_W = DEC_W + 1;
   localparam int SUM_W  = GAMMA_FRAC_BITS + 3;

   // One search stage per code bit, plus decode and sum stages
   localparam int SEARCH_STEPS = CODE_W;
   localparam int LANE_LAT     = SEARCH_STEPS + 2;
   localparam int PIPE_LAT     = LANE_LAT + 1;

   localparam logic [CODE_W-1:0] ALPHA_CUTOFF_RESET = 8'd96;

   // Width for exact table arithmetic: y^5 * 255^11 and i^11 * 2^(5(F+2))
   localparam int BIG_W = 5 * SUM_W + 11 * CODE_W + 8;

   typedef logic [DEC_W-1:0] dec_tab_type [CODE_COUNT];
   typedef logic [SUM_W-1:0] thr_tab_type [CODE_COUNT];

   typedef struct packed {
      logic                 advance;
      logic [PIX_COUNT-1:0] keep;
   } lane_ctrl_type;

   typedef struct packed {
      logic              advance;
      logic              transparent;
      logic [CODE_W-1:0] cutoff;
   } merge_ctrl_type;

   // Raise a wide value to a small power
   function automatic logic [BIG_W-1:0] pow_big(logic [BIG_W-1:0] b, int n);
      logic [BIG_W-1:0] r;
      r = BIG_W'(1);
      for (int k = 0; k < n; k++) begin
         r = r * b;
      end
      return r;
   endfunction

   // Right side of the root test: code^11 * 2^(5(F+2))
   function automatic logic [BIG_W-1:0] gamma_rhs(logic [CODE_W-1:0] code);
      return pow_big(BIG_W'(code), 11) << (5 * (GAMMA_FRAC_BITS + 2));
   endfunction

   // Left side of the root test: y^5 * 255^11
   function automatic logic [BIG_W-1:0] gamma_lhs(logic [SUM_W-1:0] y);
      return pow_big(BIG_W'(y), 5) * pow_big(BIG_W'(CODE_COUNT - 1), 11);
   endfunction

   // Largest y with y^5 * 255^11 <= code^11 * 2^(5(F+2))
   function automatic logic [SUM_W-1:0] gamma_root(logic [CODE_W-1:0] code);
      logic [BIG_W-1:0] rhs;
      logic [SUM_W-1:0] y;
      logic [SUM_W-1:0] cand;
      rhs = gamma_rhs(code);
      y   = '0;
      for (int b = SUM_W - 1; b >= 0; b--) begin
         cand = y | (SUM_W'(1) << b);
         if (gamma_lhs(cand) <= rhs) begin
            y = cand;
         end
      end
      return y;
   endfunction

   // Decode table: round-half-up of 2^F * (i/255)^2.2
   function automatic dec_tab_type build_dec_tab();
      dec_tab_type      t;
      logic [SUM_W-1:0] y;
      for (int i = 0; i < CODE_COUNT; i++) begin
         y    = gamma_root(CODE_W'(i));
         t[i] = DEC_W'(((y >> 1) + SUM_W'(1)) >> 1);
      end
      return t;
   endfunction

   // Encode thresholds: ceil of 2^(F+2) * (j/255)^2.2
   function automatic thr_tab_type build_thr_tab();
      thr_tab_type      t;
      logic [SUM_W-1:0] y;
      for (int i = 0; i < CODE_COUNT; i++) begin
         y = gamma_root(CODE_W'(i));
         if (gamma_lhs(y) == gamma_rhs(CODE_W'(i))) begin
            t[i] = y;
         end else begin
            t[i] = y + SUM_W'(1);
         end
      end
      return t;
   endfunction

   localparam dec_tab_type DEC_TAB = build_dec_tab();
   localparam thr_tab_type THR_TAB = build_thr_tab();

endpackage

@@ src/gcqpb_if.sv @@
// Input channel: four source pixels and the mode flag
interface gcqpb_req_if;
   logic                          valid;
   logic                          ready;
   logic [gcqpb_pkg::PIXEL_W-1:0] pixel_a;
   logic [gcqpb_pkg::PIXEL_W-1:0] pixel_b;
   logic [gcqpb_pkg::PIXEL_W-1:0] pixel_c;
   logic [gcqpb_pkg::PIXEL_W-1:0] pixel_d;
   logic                          transparent_mode;

   modport source (
      output valid, pixel_a, pixel_b, pixel_c, pixel_d, transparent_mode,
      input  ready
   );
   modport sink (
      input  valid, pixel_a, pixel_b, pixel_c, pixel_d, transparent_mode,
      output ready
   );
endinterface

// Result channel: one blended pixel
interface gcqpb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [gcqpb_pkg::PIXEL_W-1:0] blended_pixel;

   modport source (output valid, blended_pixel, input ready);
   modport sink (input valid, blended_pixel, output ready);
endinterface

@@ src/gcqpb_lane.sv @@
module gcqpb_lane (
   input  logic                                                clock,
   input  gcqpb_pkg::lane_ctrl_type                            ctrl,
   input  logic [gcqpb_pkg::PIX_COUNT-1:0][gcqpb_pkg::CODE_W-1:0] samples,
   output logic [gcqpb_pkg::CODE_W-1:0]                        code
);

   logic [gcqpb_pkg::DEC_W-1:0]  dec_value [gcqpb_pkg::PIX_COUNT];
   logic [gcqpb_pkg::PAIR_W-1:0] pair_in [2];
   logic [gcqpb_pkg::PAIR_W-1:0] pair_ff [2];
   logic [gcqpb_pkg::SUM_W-1:0]  sum_in;
   logic [gcqpb_pkg::SUM_W-1:0]  sum_ff [gcqpb_pkg::SEARCH_STEPS];
   logic [gcqpb_pkg::CODE_W-1:0] code_ff [gcqpb_pkg::SEARCH_STEPS];

   // Decode each sample to linear light, drop skipped pixels, add in pairs
   always_comb begin
      for (int p = 0; p < gcqpb_pkg::PIX_COUNT; p++) begin
         dec_value[p] = ctrl.keep[p] ? gcqpb_pkg::DEC_TAB[samples[p]] : '0;
      end
      for (int h = 0; h < 2; h++) begin
         pair_in[h] = gcqpb_pkg::PAIR_W'(dec_value[2*h])
                    + gcqpb_pkg::PAIR_W'(dec_value[2*h+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         pair_ff <= pair_in;
      end
   end

   // Finish the quad sum
   assign sum_in = gcqpb_pkg::SUM_W'(pair_ff[0]) + gcqpb_pkg::SUM_W'(pair_ff[1]);

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         sum_ff[0] <= sum_in;
      end
   end

   // Re-encode: one threshold compare per stage, most significant code bit first
   for (genvar k = 0; k < gcqpb_pkg::SEARCH_STEPS; k++) begin : g_search
      logic [gcqpb_pkg::CODE_W-1:0] base_code;
      logic [gcqpb_pkg::CODE_W-1:0] cand_code;
      logic [gcqpb_pkg::CODE_W-1:0] code_in;

      if (k == 0) begin : g_first
         assign base_code = '0;
      end else begin : g_rest
         assign base_code = code_ff[k-1];
      end

      assign cand_code = base_code
                       | (gcqpb_pkg::CODE_W'(1) << (gcqpb_pkg::CODE_W - 1 - k));
      assign code_in   = (sum_ff[k] >= gcqpb_pkg::THR_TAB[cand_code]) ? cand_code
                                                                      : base_code;

      always_ff @(posedge clock) begin
         if (ctrl.advance) begin
            code_ff[k] <= code_in;
         end
      end

      if (k < gcqpb_pkg::SEARCH_STEPS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (ctrl.advance) begin
               sum_ff[k+1] <= sum_ff[k];
            end
         end
      end
   end

   assign code = code_ff[gcqpb_pkg::SEARCH_STEPS-1];

endmodule

@@ src/gcqpb_merge.sv @@
module gcqpb_merge (
   input  logic                                               clock,
   input  gcqpb_pkg::merge_ctrl_type                          ctrl,
   input  logic [gcqpb_pkg::CH_COUNT-1:0][gcqpb_pkg::CODE_W-1:0] codes,
   output logic [gcqpb_pkg::PIXEL_W-1:0]                      pixel
);

   logic [gcqpb_pkg::CODE_W-1:0]                          alpha_code;
   logic [gcqpb_pkg::CH_COUNT-1:0][gcqpb_pkg::CODE_W-1:0] merged;
   logic [gcqpb_pkg::PIXEL_W-1:0]                         pixel_in;
   logic [gcqpb_pkg::PIXEL_W-1:0]                         pixel_ff;

   // Clear a faint alpha in transparent mode
   assign alpha_code = (ctrl.transparent
                        && (codes[gcqpb_pkg::ALPHA_CH] < ctrl.cutoff)) ? '0
                     : codes[gcqpb_pkg::ALPHA_CH];

   // Pack channels back into ARGB
   always_comb begin
      merged                      = codes;
      merged[gcqpb_pkg::ALPHA_CH] = alpha_code;
      pixel_in                    = merged;
   end

   // Hold the result until the receiver takes it
   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         pixel_ff <= pixel_in;
      end
   end

   assign pixel = pixel_ff;

endmodule

@@ src/gamma_correct_quad_pixel_blend.sv @@
// Gamma-correct 2x2 blend of four ARGB pixels into one.
// req_port (valid/ready) carries pixel_a..pixel_d and transparent_mode; an item
// is taken at a clock edge with valid and ready high. rsp_port (valid/ready)
// returns blended_pixel, one result per item, in order.
// csr_write_enable/csr_write_data load alpha_cutoff; write it only while idle.
// Each of the four ARGB channels runs in its own lane: table decode, a
// two-level adder, then eight compare stages that rebuild the output code one
// bit per stage against the encode thresholds. A merge stage applies the
// alpha cutoff and registers the pixel.
// Throughput: one item per cycle while rsp_port does not stall, set by the fully pipelined lanes.
// Stall: while a result waits and rsp_port.ready is low, the whole pipeline
// holds and req_port.ready drops; an empty output stage keeps ready high.
// Reset (synchronous, active high) drops every item in flight and sets
// alpha_cutoff to 96.
`include "gamma_correct_quad_pixel_blend_macros.svh"

module gamma_correct_quad_pixel_blend (
   input  logic                          clock,
   input  logic                          reset,
   gcqpb_req_if.sink                     req_port,
   gcqpb_rsp_if.source                   rsp_port,
   input  logic                          csr_write_enable,
   input  logic [gcqpb_pkg::CODE_W-1:0]  csr_write_data
);

   logic                                                   advance;
   logic [gcqpb_pkg::PIPE_LAT-1:0]                         valid_in;
   logic [gcqpb_pkg::PIPE_LAT-1:0]                         valid_ff;
   logic [gcqpb_pkg::LANE_LAT-1:0]                         tm_in;
   logic [gcqpb_pkg::LANE_LAT-1:0]                         tm_ff;
   logic [gcqpb_pkg::CODE_W-1:0]                           cutoff_in;
   logic [gcqpb_pkg::CODE_W-1:0]                           cutoff_ff;
   logic [gcqpb_pkg::PIX_COUNT-1:0][gcqpb_pkg::PIXEL_W-1:0] pix;
   logic [gcqpb_pkg::CH_COUNT-1:0][gcqpb_pkg::CODE_W-1:0]   codes;
   gcqpb_pkg::lane_ctrl_type                               lane_ctrl;
   gcqpb_pkg::merge_ctrl_type                              merge_ctrl;

   // Advance the pipeline unless a result sits unaccepted
   assign advance        = !valid_ff[gcqpb_pkg::PIPE_LAT-1] || rsp_port.ready;
   assign req_port.ready = advance;

   // Track which stages hold a live item
   assign valid_in = {valid_ff[gcqpb_pkg::PIPE_LAT-2:0], req_port.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // Carry the mode flag alongside the lanes
   assign tm_in = {tm_ff[gcqpb_pkg::LANE_LAT-2:0], req_port.transparent_mode};

   always_ff @(posedge clock) begin
      if (advance) begin
         tm_ff <= tm_in;
      end
   end

   // Cutoff register
   assign cutoff_in = csr_write_enable ? csr_write_data : cutoff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff <= gcqpb_pkg::ALPHA_CUTOFF_RESET;
      end else begin
         cutoff_ff <= cutoff_in;
      end
   end

   // Gather pixels and mark the ones to skip
   always_comb begin
      pix[0] = req_port.pixel_a;
      pix[1] = req_port.pixel_b;
      pix[2] = req_port.pixel_c;
      pix[3] = req_port.pixel_d;
      lane_ctrl.advance = advance;
      for (int p = 0; p < gcqpb_pkg::PIX_COUNT; p++) begin
         lane_ctrl.keep[p] = !req_port.transparent_mode
            || (pix[p][gcqpb_pkg::ALPHA_CH*gcqpb_pkg::CODE_W +: gcqpb_pkg::CODE_W] != '0);
      end
   end

   // One lane per ARGB channel
   for (genvar ch = 0; ch < gcqpb_pkg::CH_COUNT; ch++) begin : g_lane
      logic [gcqpb_pkg::PIX_COUNT-1:0][gcqpb_pkg::CODE_W-1:0] samples;

      always_comb begin
         for (int p = 0; p < gcqpb_pkg::PIX_COUNT; p++) begin
            samples[p] = pix[p][ch*gcqpb_pkg::CODE_W +: gcqpb_pkg::CODE_W];
         end
      end

      gcqpb_lane u_lane (
         .clock   (clock),
         .ctrl    (lane_ctrl),
         .samples (samples),
         .code    (codes[ch])
      );
   end

   // Merge the channel codes into the output pixel
   assign merge_ctrl.advance     = advance;
   assign merge_ctrl.transparent = tm_ff[gcqpb_pkg::LANE_LAT-1];
   assign merge_ctrl.cutoff      = cutoff_ff;

   gcqpb_merge u_merge (
      .clock (clock),
      .ctrl  (merge_ctrl),
      .codes (codes),
      .pixel (rsp_port.blended_pixel)
   );

   assign rsp_port.valid = valid_ff[gcqpb_pkg::PIPE_LAT-1];

   // An empty output stage never blocks the input side
   `GCQPB_ASSERT_SAME(a_empty_out_ready, clock, reset,
      !rsp_port.valid, req_port.ready)
   // A stalled result freezes every stage
   `GCQPB_ASSERT_NEXT(a_stall_freezes, clock, reset,
      rsp_port.valid && !rsp_port.ready, $stable(valid_ff))
   // Reset leaves nothing in flight
   `GCQPB_ASSERT_NEXT(a_reset_empties, clock, 1'b0,
      reset, valid_ff == '0)

endmodule

@@ tb/tb_gamma_correct_quad_pixel_blend.sv @@
module tb_gamma_correct_quad_pixel_blend;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [gcqpb_pkg::PIX_COUNT-1:0][gcqpb_pkg::PIXEL_W-1:0] quad_type;
   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_CHOKED, RX_RHYTHM} rx_mode_type;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_QUADS  = 350;
   localparam int SETTLE_TICKS = gcqpb_pkg::PIPE_LAT + 4;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         csr_write_enable;
   logic [gcqpb_pkg::CODE_W-1:0] csr_write_data;

   gcqpb_req_if req_bus ();
   gcqpb_rsp_if rsp_bus ();

   // Linear-light decode per code, and the lowest quad sum that reaches each code
   logic [gcqpb_pkg::DEC_W-1:0]   linear_of_code [gcqpb_pkg::CODE_COUNT];
   logic [gcqpb_pkg::SUM_W-1:0]   code_threshold [gcqpb_pkg::CODE_COUNT];
   logic [gcqpb_pkg::CODE_W-1:0]  cutoff_shadow;
   logic [gcqpb_pkg::PIXEL_W-1:0] pending_blends [$];
   logic [gcqpb_pkg::PIXEL_W-1:0] want_pixel;

   int          error_count    = 0;
   int          cycle_count    = 0;
   int          quads_sent     = 0;
   int          directed_quads = 0;
   int          blends_checked = 0;
   int          cutoff_writes  = 0;
   int          burst_left     = 0;
   rx_mode_type rx_mode        = RX_OPEN;
   int          rx_hold        = 0;

   gamma_correct_quad_pixel_blend uut (
      .clock            (clock),
      .reset            (reset),
      .req_port         (req_bus),
      .rsp_port         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Largest y with y^5 * 255^11 <= code^11 * 2^(5(F+2)); flag an exact hit
   function automatic void solve_gamma_root(input int code,
                                            output logic [gcqpb_pkg::SUM_W-1:0] root,
                                            output bit exact);
      logic [255:0]                scale;
      logic [255:0]                target;
      logic [255:0]                trial;
      logic [gcqpb_pkg::SUM_W-1:0] cand;
      scale  = 256'd1;
      target = 256'd1;
      for (int k = 0; k < 11; k++) begin
         scale  = scale * 256'd255;
         target = target * 256'(code);
      end
      target = target << (5 * (gcqpb_pkg::GAMMA_FRAC_BITS + 2));
      root = '0;
      for (int b = gcqpb_pkg::SUM_W - 1; b >= 0; b--) begin
         cand  = root | (gcqpb_pkg::SUM_W'(1) << b);
         trial = scale;
         for (int k = 0; k < 5; k++) trial = trial * 256'(cand);
         if (trial <= target) root = cand;
      end
      trial = scale;
      for (int k = 0; k < 5; k++) trial = trial * 256'(root);
      exact = (trial == target);
   endfunction

   function automatic void build_gamma_tables();
      logic [gcqpb_pkg::SUM_W-1:0] root;
      bit                          exact;
      for (int i = 0; i < gcqpb_pkg::CODE_COUNT; i++) begin
         solve_gamma_root(i, root, exact);
         linear_of_code[i] = gcqpb_pkg::DEC_W'(((root >> 1) + 1) >> 1);
         code_threshold[i] = exact ? root : root + gcqpb_pkg::SUM_W'(1);
      end
   endfunction

   // Sum decoded light per channel, re-encode by threshold count, apply cutoff
   function automatic logic [gcqpb_pkg::PIXEL_W-1:0] blend_quad(
         quad_type quad, logic tm, logic [gcqpb_pkg::CODE_W-1:0] cutoff);
      logic [gcqpb_pkg::SUM_W-1:0]   light;
      logic [gcqpb_pkg::CODE_W-1:0]  code;
      logic [gcqpb_pkg::PIXEL_W-1:0] blended;
      blended = '0;
      for (int ch = 0; ch < gcqpb_pkg::CH_COUNT; ch++) begin
         light = '0;
         for (int p = 0; p < gcqpb_pkg::PIX_COUNT; p++) begin
            if (!(tm && quad[p][gcqpb_pkg::PIXEL_W-1 -: gcqpb_pkg::CODE_W] == '0))
               light = light + gcqpb_pkg::SUM_W'(
                  linear_of_code[quad[p][ch*gcqpb_pkg::CODE_W +: gcqpb_pkg::CODE_W]]);
         end
         code = '0;
         for (int j = 1; j < gcqpb_pkg::CODE_COUNT; j++) begin
            if (light >= code_threshold[j]) code = code + 1'b1;
         end
         blended[ch*gcqpb_pkg::CODE_W +: gcqpb_pkg::CODE_W] = code;
      end
      if (tm && blended[gcqpb_pkg::PIXEL_W-1 -: gcqpb_pkg::CODE_W] < cutoff)
         blended[gcqpb_pkg::PIXEL_W-1 -: gcqpb_pkg::CODE_W] = '0;
      return blended;
   endfunction

   // Random pixel with alpha biased toward zero, opaque and the current cutoff
   function automatic logic [gcqpb_pkg::PIXEL_W-1:0] random_pixel();
      logic [gcqpb_pkg::PIXEL_W-1:0] pix;
      int                            sel;
      pix = $urandom();
      case ($urandom_range(0, 9)) inside
         [0:1]: pix[gcqpb_pkg::PIXEL_W-1 -: gcqpb_pkg::CODE_W] = '0;
         2: pix[gcqpb_pkg::PIXEL_W-1 -: gcqpb_pkg::CODE_W] = '1;
         3: pix[gcqpb_pkg::PIXEL_W-1 -: gcqpb_pkg::CODE_W] =
               cutoff_shadow + gcqpb_pkg::CODE_W'($urandom_range(0, 2)) - 1'b1;
         default: ;
      endcase
      if ($urandom_range(0, 7) == 0) begin
         sel = $urandom_range(0, 2);
         pix[sel*gcqpb_pkg::CODE_W +: gcqpb_pkg::CODE_W] =
            $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      return pix;
   endfunction

   // Present one quad, idling between bursts; return at the accepting edge
   task automatic send_quad(input quad_type quad, input logic tm);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                 : $urandom_range(1, 12);
         gap = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 2);
         if (gap > 0) begin
            req_bus.valid            <= 1'b0;
            req_bus.pixel_a          <= $urandom();
            req_bus.pixel_b          <= $urandom();
            req_bus.pixel_c          <= $urandom();
            req_bus.pixel_d          <= $urandom();
            req_bus.transparent_mode <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid            <= 1'b1;
      req_bus.pixel_a          <= quad[0];
      req_bus.pixel_b          <= quad[1];
      req_bus.pixel_c          <= quad[2];
      req_bus.pixel_d          <= quad[3];
      req_bus.transparent_mode <= tm;
      do @(posedge clock); while (!req_bus.ready);
      quads_sent++;
   endtask

   // Drop valid and hold until every outstanding blend has come back
   task automatic wait_until_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_blends.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_cutoff(input logic [gcqpb_pkg::CODE_W-1:0] value);
      wait_until_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      csr_write_data   <= gcqpb_pkg::CODE_W'($urandom());
      cutoff_shadow = value;
      cutoff_writes++;
   endtask

   // Black, white, bit patterns and single-channel maxima; white in both modes
   task automatic test_extremes();
      send_quad({4{32'h0000_0000}}, 1'b0);
      send_quad({4{32'hFFFF_FFFF}}, 1'b0);
      send_quad({4{32'hFFFF_FFFF}}, 1'b1);
      send_quad({32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF}, 1'b0);
      send_quad({4{32'hAAAA_AAAA}}, 1'b0);
      send_quad({32'h0000_00FF, 32'h0000_FF00, 32'h00FF_0000, 32'hFF00_0000}, 1'b0);
   endtask

   // Zero-alpha pixels: skipped in transparent mode, still divided by four
   task automatic test_transparency();
      send_quad({4{32'h0000_0000}}, 1'b1);
      send_quad({4{32'h00FF_FFFF}}, 1'b1);
      send_quad({32'h00FF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF, 32'hFFFF_FFFF}, 1'b1);
      send_quad({32'h00FF_FFFF, 32'h8040_2010, 32'h00AB_CDEF, 32'h0012_3456}, 1'b1);
      send_quad({32'h00FF_FFFF, 32'h8040_2010, 32'h00AB_CDEF, 32'h0012_3456}, 1'b0);
      send_quad({4{32'h5555_5555}}, 1'b1);
   endtask

   // Alpha just under, at and over the cutoff, with the cutoff at its extremes
   task automatic test_cutoff_edges();
      write_cutoff(8'd200);
      send_quad({4{32'hC780_8080}}, 1'b1);
      send_quad({4{32'hC880_8080}}, 1'b1);
      send_quad({4{32'hC980_8080}}, 1'b1);
      send_quad({4{32'hC780_8080}}, 1'b0);
      write_cutoff(8'd0);
      send_quad({4{32'h0120_4060}}, 1'b1);
      send_quad({32'h0011_2233, 32'h0011_2233, 32'h0011_2233, 32'h0120_4060}, 1'b1);
      write_cutoff(8'd255);
      send_quad({4{32'hFE10_2030}}, 1'b1);
      send_quad({4{32'hFF10_2030}}, 1'b1);
   endtask

   // Random quads under several cutoff settings
   task automatic test_random_blends();
      logic [gcqpb_pkg::CODE_W-1:0]  phase_cutoff [4];
      logic [gcqpb_pkg::PIXEL_W-1:0] base;
      quad_type                      quad;
      phase_cutoff = '{gcqpb_pkg::CODE_W'($urandom()), 8'd0, 8'd255,
                       gcqpb_pkg::CODE_W'($urandom())};
      for (int ph = 0; ph < 4; ph++) begin
         write_cutoff(phase_cutoff[ph]);
         for (int n = 0; n < PHASE_QUADS; n++) begin
            case ($urandom_range(0, 3))
               0: quad = {random_pixel(), random_pixel(), random_pixel(), random_pixel()};
               1: begin
                  base = random_pixel();
                  quad = {4{base}};
               end
               2: begin
                  base = random_pixel();
                  for (int p = 0; p < gcqpb_pkg::PIX_COUNT; p++)
                     quad[p] = base ^ ($urandom() & 32'h0303_0303);
               end
               default: quad = {$urandom(), $urandom(), $urandom(), $urandom()};
            endcase
            send_quad(quad, $urandom_range(0, 4) != 0);
         end
      end
   endtask

   // Receiver: switch between open, coin-flip, choked and rhythmic stalling
   always @(posedge clock) begin
      if (rx_hold == 0) begin
         rx_mode <= rx_mode_type'($urandom_range(0, 3));
         rx_hold <= $urandom_range(16, 240);
      end else begin
         rx_hold <= rx_hold - 1;
      end
      case (rx_mode)
         RX_OPEN: rsp_bus.ready <= 1'b1;
         RX_COIN: rsp_bus.ready <= 1'($urandom_range(0, 1));
         RX_CHOKED: rsp_bus.ready <= ($urandom_range(0, 4) == 0);
         default: rsp_bus.ready <= (cycle_count % 7) < 4;
      endcase
   end

   // Predict on acceptance, compare each result with the oldest prediction
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            pending_blends.push_back(blend_quad({req_bus.pixel_d, req_bus.pixel_c,
                                                 req_bus.pixel_b, req_bus.pixel_a},
                                                req_bus.transparent_mode, cutoff_shadow));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_blends.size() == 0) begin
               $error("blended_pixel %08h arrived with no quad outstanding",
                      rsp_bus.blended_pixel);
               error_count++;
            end else begin
               want_pixel = pending_blends.pop_front();
               blends_checked++;
               if (rsp_bus.blended_pixel !== want_pixel) begin
                  $error("blended_pixel mismatch: expected %08h, actual %08h",
                         want_pixel, rsp_bus.blended_pixel);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin
      reset                    = 1'b1;
      csr_write_enable         = 1'b0;
      csr_write_data           = '0;
      req_bus.valid            = 1'b0;
      req_bus.pixel_a          = '0;
      req_bus.pixel_b          = '0;
      req_bus.pixel_c          = '0;
      req_bus.pixel_d          = '0;
      req_bus.transparent_mode = 1'b0;
      rsp_bus.ready            = 1'b0;
      cutoff_shadow            = gcqpb_pkg::ALPHA_CUTOFF_RESET;
      build_gamma_tables();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_extremes();
      test_transparency();
      test_cutoff_edges();
      directed_quads = quads_sent;
      test_random_blends();
      wait_until_idle();

      $display("Sent %0d quads (%0d directed, %0d random), checked %0d blended pixels",
               quads_sent, directed_quads, quads_sent - directed_quads, blends_checked);
      $display("Wrote alpha_cutoff %0d times, including 0 and 255, in both blend modes",
               cutoff_writes);
      if (error_count == 0 && pending_blends.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
